/* rtl/core/hpac_pkg.sv */
// shared constants, types and helpers for the homogeneous polygon axis clipper
package hpac_pkg;

  localparam int MAX_VERTICES = 10;
  localparam int FRAC_BITS    = 16;
  localparam int NFIELDS      = 6;
  localparam int DATA_W       = 32;

  localparam int DEPTH   = 2 * MAX_VERTICES;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
  localparam int IDX_W   = $clog2(MAX_VERTICES);
  localparam int FLD_W   = $clog2(NFIELDS);
  localparam int DIST_W  = DATA_W + 2;
  localparam int DEN_W   = DATA_W + 3;
  localparam int REM_W   = DEN_W + 1;
  localparam int TQ_W    = FRAC_BITS + 1;
  localparam int STEP_W  = $clog2(TQ_W);
  localparam int PROD_W  = DATA_W + 1 + TQ_W + 1;
  localparam int VTX_W   = NFIELDS * DATA_W;

  localparam int F_X = 0;
  localparam int F_Y = 1;
  localparam int F_Z = 2;
  localparam int F_W = 3;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef logic [NFIELDS-1:0][DATA_W-1:0] vtx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PASS_INIT,
    S_PREV_LAT,
    S_CUR_RD,
    S_CUR_LAT,
    S_DIV,
    S_MUL,
    S_ADD,
    S_WR_MID,
    S_WR_CUR,
    S_NEXT,
    S_OUT_RD,
    S_OUT_EMIT,
    S_EMPTY
  } state_t;

  // signed distance w - c' to the plane, c' = -c when neg is set
  function automatic logic signed [DIST_W-1:0] plane_dist(input vtx_t v,
                                                          input logic [1:0] axis,
                                                          input logic neg);
    logic signed [DIST_W-1:0] c;
    logic signed [DIST_W-1:0] w;
    logic [DATA_W-1:0] comp;
    unique case (axis)
      AXIS_X:  comp = v[F_X];
      AXIS_Y:  comp = v[F_Y];
      AXIS_Z:  comp = v[F_Z];
      default: comp = '0;
    endcase
    c = signed'({{(DIST_W-DATA_W){comp[DATA_W-1]}}, comp});
    w = signed'({{(DIST_W-DATA_W){v[F_W][DATA_W-1]}}, v[F_W]});
    return neg ? (w + c) : (w - c);
  endfunction

endpackage

/* rtl/core/hpac_ram.sv */
// generic single write port ram with registered read
module hpac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/homogeneous_polygon_axis_clipper.sv */
// top level: polygon vertex store, two-plane clip sequencer with shared divide and multiply
//
// usage:
//   input channel: one polygon vertex per transaction, taken when start is high and
//   busy is low. vertices are stored; the transaction with in_last set also picks the
//   axis and launches clipping against -w <= c and c <= w of that axis.
//   result channel: out_valid is high for one cycle per result vertex; the receiver
//   cannot stall, every strobe is a transaction. out_last marks the final vertex.
//   a fully clipped polygon gives a single result with out_polygon_empty set and all
//   vertex fields zero. out_overflow flags dropped input or clipped vertices.
// sequence:
//   non-last vertex: stored, busy stays low.
//   last vertex: busy while, per pass, the closing vertex and then each source vertex
//   are read and tested; each kept vertex is written, and each crossing edge runs a
//   radix-2 divider, then one multiply and one add for each of the six fields on the
//   shared multiplier, then the write; then each result vertex is read from the vertex
//   store and emitted, read and emit alternating. the store read and the output are
//   both registered between a read address and its result.
// reset: synchronous active low; clears sequencer, vertex count and overflow.
//   the vertex store is not cleared, only written entries are ever read.
module homogeneous_polygon_axis_clipper (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [hpac_pkg::DATA_W-1:0] in_x,
  input  logic [hpac_pkg::DATA_W-1:0] in_y,
  input  logic [hpac_pkg::DATA_W-1:0] in_z,
  input  logic [hpac_pkg::DATA_W-1:0] in_w,
  input  logic [hpac_pkg::DATA_W-1:0] in_attr_a,
  input  logic [hpac_pkg::DATA_W-1:0] in_attr_b,
  input  logic [1:0]                  in_axis_select,
  input  logic                        in_last,
  output logic                        out_valid,
  output logic [hpac_pkg::DATA_W-1:0] out_x,
  output logic [hpac_pkg::DATA_W-1:0] out_y,
  output logic [hpac_pkg::DATA_W-1:0] out_z,
  output logic [hpac_pkg::DATA_W-1:0] out_w,
  output logic [hpac_pkg::DATA_W-1:0] out_attr_a,
  output logic [hpac_pkg::DATA_W-1:0] out_attr_b,
  output logic                        out_last,
  output logic                        out_polygon_empty,
  output logic                        out_overflow
);
  import hpac_pkg::*;

  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (FRAC_BITS - 1);

  // sequencer state
  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;      // vertices held
  logic                      ovf_r, ovf_nxt;
  logic [1:0]                axis_r, axis_nxt;
  logic                      pass_r, pass_nxt;    // 0: negated plane, 1: plain
  logic [CNT_W-1:0]          n_r, n_nxt;          // source vertex count
  logic [CNT_W-1:0]          m_r, m_nxt;          // destination fill
  logic [IDX_W-1:0]          i_r, i_nxt;          // source walk index
  logic [IDX_W-1:0]          k_r, k_nxt;          // output index
  // edge datapath
  vtx_t                      prev_r, prev_nxt;
  vtx_t                      cur_r, cur_nxt;
  vtx_t                      mid_r, mid_nxt;
  logic signed [DIST_W-1:0]  pd_r, pd_nxt;
  logic signed [DIST_W-1:0]  cd_r, cd_nxt;
  logic                      pin_r, pin_nxt;
  logic                      cin_r, cin_nxt;
  // divider
  logic [REM_W-1:0]          rem_r, rem_nxt;
  logic [DEN_W-1:0]          ud_r, ud_nxt;
  logic [TQ_W-1:0]           tq_r, tq_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  // interpolation
  logic [FLD_W-1:0]          f_r, f_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  // output registers
  logic                      out_valid_r, out_valid_nxt;
  vtx_t                      out_vtx_r, out_vtx_nxt;
  logic                      out_last_r, out_last_nxt;
  logic                      out_empty_r, out_empty_nxt;
  logic                      out_ovf_r, out_ovf_nxt;

  // vertex store
  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr;
  vtx_t                      ram_wdata;
  logic [ADDR_W-1:0]         ram_raddr;
  logic [VTX_W-1:0]          ram_rdata;
  vtx_t                      rd_vtx;

  // combinational helpers
  logic [ADDR_W-1:0]         src_base, dst_base;
  logic signed [DIST_W-1:0]  rd_dist;
  logic signed [DEN_W-1:0]   den;
  logic signed [DATA_W:0]    fdiff;
  logic signed [TQ_W:0]      tq_s;
  logic signed [PROD_W-1:0]  rnd;
  logic signed [PROD_W-1:0]  shr;
  logic [REM_W-1:0]          rem_sub;
  logic                      qbit;
  vtx_t                      in_vtx;

  hpac_ram #(
    .WIDTH (VTX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_vtx   = vtx_t'(ram_rdata);
  assign in_vtx   = {in_attr_b, in_attr_a, in_w, in_z, in_y, in_x};
  assign src_base = pass_r ? ADDR_W'(MAX_VERTICES) : '0;
  assign dst_base = pass_r ? '0 : ADDR_W'(MAX_VERTICES);
  assign rd_dist  = plane_dist(rd_vtx, axis_r, !pass_r);
  assign busy     = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    axis_nxt      = axis_r;
    pass_nxt      = pass_r;
    n_nxt         = n_r;
    m_nxt         = m_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    mid_nxt       = mid_r;
    pd_nxt        = pd_r;
    cd_nxt        = cd_r;
    pin_nxt       = pin_r;
    cin_nxt       = cin_r;
    rem_nxt       = rem_r;
    ud_nxt        = ud_r;
    tq_nxt        = tq_r;
    step_nxt      = step_r;
    f_nxt         = f_r;
    prod_nxt      = prod_r;
    out_valid_nxt = 1'b0;
    out_vtx_nxt   = out_vtx_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    out_ovf_nxt   = out_ovf_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = in_vtx;
    ram_raddr     = '0;
    den           = signed'(DEN_W'(pd_r)) - signed'(DEN_W'(rd_dist));
    fdiff         = signed'({cur_r[f_r][DATA_W-1], cur_r[f_r]})
                  - signed'({prev_r[f_r][DATA_W-1], prev_r[f_r]});
    tq_s          = signed'({1'b0, tq_r});
    rnd           = prod_r + HALF;
    shr           = rnd >>> FRAC_BITS;
    qbit          = (rem_r >= {1'b0, ud_r});
    rem_sub       = qbit ? (rem_r - {1'b0, ud_r}) : rem_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (cnt_r < CNT_W'(MAX_VERTICES)) begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(cnt_r);
            cnt_nxt   = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            axis_nxt  = in_axis_select;
            pass_nxt  = 1'b0;
            n_nxt     = cnt_nxt;
            state_nxt = S_PASS_INIT;
          end
        end
      end
      S_PASS_INIT: begin
        m_nxt = '0;
        i_nxt = '0;
        if (n_r == '0) begin
          state_nxt = S_EMPTY;
        end else begin
          ram_raddr = src_base + ADDR_W'(n_r) - 1'b1;
          state_nxt = S_PREV_LAT;
        end
      end
      S_PREV_LAT: begin
        prev_nxt  = rd_vtx;
        pd_nxt    = rd_dist;
        pin_nxt   = !rd_dist[DIST_W-1];
        state_nxt = S_CUR_RD;
      end
      S_CUR_RD: begin
        ram_raddr = src_base + ADDR_W'(i_r);
        state_nxt = S_CUR_LAT;
      end
      S_CUR_LAT: begin
        cur_nxt = rd_vtx;
        cd_nxt  = rd_dist;
        cin_nxt = !rd_dist[DIST_W-1];
        if (pin_r != !rd_dist[DIST_W-1]) begin
          // crossing edge: t = |pd| / |pd - cd|
          rem_nxt   = pd_r[DIST_W-1] ? REM_W'(-pd_r) : REM_W'(pd_r);
          ud_nxt    = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
          tq_nxt    = '0;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end else if (!rd_dist[DIST_W-1]) begin
          state_nxt = S_WR_CUR;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_DIV: begin
        rem_nxt = rem_sub << 1;
        tq_nxt  = {tq_r[TQ_W-2:0], qbit};
        if (step_r == STEP_W'(TQ_W - 1)) begin
          f_nxt     = '0;
          state_nxt = S_MUL;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_MUL: begin
        prod_nxt  = fdiff * tq_s;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        mid_nxt[f_r] = prev_r[f_r] + shr[DATA_W-1:0];
        if (f_r == FLD_W'(NFIELDS - 1)) begin
          state_nxt = S_WR_MID;
        end else begin
          f_nxt     = f_r + 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_WR_MID: begin
        if (m_r < CNT_W'(MAX_VERTICES)) begin
          ram_we    = 1'b1;
          ram_waddr = dst_base + ADDR_W'(m_r);
          ram_wdata = mid_r;
          m_nxt     = m_r + 1'b1;
        end else begin
          ovf_nxt = 1'b1;
        end
        state_nxt = cin_r ? S_WR_CUR : S_NEXT;
      end
      S_WR_CUR: begin
        if (m_r < CNT_W'(MAX_VERTICES)) begin
          ram_we    = 1'b1;
          ram_waddr = dst_base + ADDR_W'(m_r);
          ram_wdata = cur_r;
          m_nxt     = m_r + 1'b1;
        end else begin
          ovf_nxt = 1'b1;
        end
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        prev_nxt = cur_r;
        pd_nxt   = cd_r;
        pin_nxt  = cin_r;
        if ((CNT_W'(i_r) + 1'b1) == n_r) begin
          // end of pass
          if (m_r == '0) begin
            state_nxt = S_EMPTY;
          end else if (!pass_r) begin
            pass_nxt  = 1'b1;
            n_nxt     = m_r;
            state_nxt = S_PASS_INIT;
          end else begin
            n_nxt     = m_r;
            k_nxt     = '0;
            state_nxt = S_OUT_RD;
          end
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_CUR_RD;
        end
      end
      S_OUT_RD: begin
        ram_raddr = ADDR_W'(k_r);
        state_nxt = S_OUT_EMIT;
      end
      S_OUT_EMIT: begin
        out_valid_nxt = 1'b1;
        out_vtx_nxt   = rd_vtx;
        out_last_nxt  = ((CNT_W'(k_r) + 1'b1) == n_r);
        out_empty_nxt = 1'b0;
        out_ovf_nxt   = ovf_r;
        if ((CNT_W'(k_r) + 1'b1) == n_r) begin
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_OUT_RD;
        end
      end
      S_EMPTY: begin
        out_valid_nxt = 1'b1;
        out_vtx_nxt   = '0;
        out_last_nxt  = 1'b1;
        out_empty_nxt = 1'b1;
        out_ovf_nxt   = ovf_r;
        cnt_nxt       = '0;
        ovf_nxt       = 1'b0;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      m_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      m_r         <= m_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    axis_r      <= axis_nxt;
    pass_r      <= pass_nxt;
    n_r         <= n_nxt;
    i_r         <= i_nxt;
    k_r         <= k_nxt;
    prev_r      <= prev_nxt;
    cur_r       <= cur_nxt;
    mid_r       <= mid_nxt;
    pd_r        <= pd_nxt;
    cd_r        <= cd_nxt;
    pin_r       <= pin_nxt;
    cin_r       <= cin_nxt;
    rem_r       <= rem_nxt;
    ud_r        <= ud_nxt;
    tq_r        <= tq_nxt;
    step_r      <= step_nxt;
    f_r         <= f_nxt;
    prod_r      <= prod_nxt;
    out_vtx_r   <= out_vtx_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_x             = out_vtx_r[0];
  assign out_y             = out_vtx_r[1];
  assign out_z             = out_vtx_r[2];
  assign out_w             = out_vtx_r[3];
  assign out_attr_a        = out_vtx_r[4];
  assign out_attr_b        = out_vtx_r[5];
  assign out_last          = out_last_r;
  assign out_polygon_empty = out_empty_r;
  assign out_overflow      = out_ovf_r;

  // an empty polygon is always a single, final result
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_polygon_empty |-> out_last)
    else $error("empty result without last mark");

  // results only come from the two emit states
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_nxt |-> (state_r == S_OUT_EMIT || state_r == S_EMPTY))
    else $error("result strobe outside emit");

  // a crossing edge never divides by zero
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> ud_r != '0)
    else $error("divider entered with zero denominator");

  // fill counts stay within one bank
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_VERTICES) && m_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond capacity");

  // an empty result drops busy and clears the vertex count
  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMPTY |=> !busy && cnt_r == '0)
    else $error("block did not return to idle after empty result");

endmodule

/* test/tb_homogeneous_polygon_axis_clipper.sv */
// self-checking testbench for the homogeneous polygon axis clipper
module tb_homogeneous_polygon_axis_clipper;
  import hpac_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    word_t x, y, z, w, a, b;
  } vertex_t;

  typedef struct packed {
    vertex_t v;
    logic    last;
    logic    empty;
    logic    ovf;
  } clip_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [DATA_W-1:0] in_x = '0, in_y = '0, in_z = '0, in_w = '0;
  logic [DATA_W-1:0] in_attr_a = '0, in_attr_b = '0;
  logic [1:0] in_axis_select = AXIS_X;
  logic in_last = 1'b0;
  logic out_valid;
  logic [DATA_W-1:0] out_x, out_y, out_z, out_w, out_attr_a, out_attr_b;
  logic out_last, out_polygon_empty, out_overflow;

  // predictor state: vertices of the polygon being loaded
  vertex_t   poly_verts[$];
  logic      poly_ovf;
  clip_out_t clipped_q[$];
  int        fail_count = 0;
  int        vertex_total = 0;
  int        polygon_total = 0;
  int        result_total = 0;
  longint    cycle_count = 0;

  homogeneous_polygon_axis_clipper dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("homogeneous_polygon_axis_clipper regression: fail");
      $finish;
    end
  end

  // ---------------- predictor ----------------

  function automatic word_t field_of(vertex_t v, int f);
    case (f)
      0: return v.x;
      1: return v.y;
      2: return v.z;
      3: return v.w;
      4: return v.a;
      default: return v.b;
    endcase
  endfunction

  function automatic vertex_t with_field(vertex_t v, int f, word_t val);
    case (f)
      0: v.x = val;
      1: v.y = val;
      2: v.z = val;
      3: v.w = val;
      4: v.a = val;
      default: v.b = val;
    endcase
    return v;
  endfunction

  // signed distance to the plane, inside when >= 0
  function automatic longint dist_to_plane(vertex_t v, logic [1:0] axis, bit negated);
    longint comp;
    case (axis)
      AXIS_X:  comp = v.x;
      AXIS_Y:  comp = v.y;
      AXIS_Z:  comp = v.z;
      default: comp = 0;
    endcase
    if (negated) comp = -comp;
    return longint'(v.w) - comp;
  endfunction

  // v1 + round((v2 - v1) * tq / 2^FRAC_BITS), ties rounded up
  function automatic word_t blend(word_t v1, word_t v2, longint tq);
    longint prod, r;
    prod = (longint'(v2) - longint'(v1)) * tq + (64'sd1 <<< (FRAC_BITS - 1));
    r = prod >>> FRAC_BITS;
    return word_t'(longint'(v1) + r);
  endfunction

  function automatic void keep_vertex(ref vertex_t dst[$], input vertex_t v, ref logic ovf);
    if (dst.size() < MAX_VERTICES) dst.push_back(v);
    else ovf = 1'b1;
  endfunction

  function automatic void clip_plane(input vertex_t src[$], ref vertex_t dst[$],
                                     input logic [1:0] axis, input bit negated,
                                     ref logic ovf);
    vertex_t prev, cur, mid;
    longint pd, cd, num, den, tq;
    bit pin, cin;
    dst = {};
    if (src.size() == 0) return;
    prev = src[src.size()-1];
    pd = dist_to_plane(prev, axis, negated);
    pin = pd >= 0;
    foreach (src[i]) begin
      cur = src[i];
      cd = dist_to_plane(cur, axis, negated);
      cin = cd >= 0;
      if (pin != cin) begin
        num = pd < 0 ? -pd : pd;
        den = pd - cd;
        if (den < 0) den = -den;
        tq = den != 0 ? (num <<< FRAC_BITS) / den : 0;
        mid = '0;
        for (int f = 0; f < NFIELDS; f++)
          mid = with_field(mid, f, blend(field_of(prev, f), field_of(cur, f), tq));
        keep_vertex(dst, mid, ovf);
      end
      if (cin) keep_vertex(dst, cur, ovf);
      prev = cur;
      pd = cd;
      pin = cin;
    end
  endfunction

  // record one accepted vertex; on the last one predict the clipped polygon
  function automatic void predict_vertex(vertex_t v, logic [1:0] axis, logic last);
    vertex_t inner[$], outer[$];
    clip_out_t r;
    if (poly_verts.size() < MAX_VERTICES) poly_verts.push_back(v);
    else poly_ovf = 1'b1;
    if (!last) return;
    clip_plane(poly_verts, inner, axis, 1'b1, poly_ovf);
    if (inner.size() != 0) clip_plane(inner, outer, axis, 1'b0, poly_ovf);
    if (outer.size() == 0) begin
      r = '0;
      r.last = 1'b1;
      r.empty = 1'b1;
      r.ovf = poly_ovf;
      clipped_q.push_back(r);
    end else begin
      foreach (outer[k]) begin
        r.v = outer[k];
        r.last = (k == outer.size() - 1);
        r.empty = 1'b0;
        r.ovf = poly_ovf;
        clipped_q.push_back(r);
      end
    end
    poly_verts = {};
    poly_ovf = 1'b0;
    polygon_total++;
  endfunction

  // ---------------- result checker ----------------

  always @(posedge clk) begin
    clip_out_t want;
    if (rst_n && out_valid) begin
      result_total++;
      if (clipped_q.size() == 0) begin
        $error("unexpected result transaction, x %h", out_x);
        fail_count++;
      end else begin
        want = clipped_q.pop_front();
        if (out_x !== want.v.x) begin
          $error("out_x expected %h got %h", want.v.x, out_x); fail_count++;
        end
        if (out_y !== want.v.y) begin
          $error("out_y expected %h got %h", want.v.y, out_y); fail_count++;
        end
        if (out_z !== want.v.z) begin
          $error("out_z expected %h got %h", want.v.z, out_z); fail_count++;
        end
        if (out_w !== want.v.w) begin
          $error("out_w expected %h got %h", want.v.w, out_w); fail_count++;
        end
        if (out_attr_a !== want.v.a) begin
          $error("out_attr_a expected %h got %h", want.v.a, out_attr_a); fail_count++;
        end
        if (out_attr_b !== want.v.b) begin
          $error("out_attr_b expected %h got %h", want.v.b, out_attr_b); fail_count++;
        end
        if (out_last !== want.last) begin
          $error("out_last expected %b got %b", want.last, out_last); fail_count++;
        end
        if (out_polygon_empty !== want.empty) begin
          $error("out_polygon_empty expected %b got %b", want.empty, out_polygon_empty);
          fail_count++;
        end
        if (out_overflow !== want.ovf) begin
          $error("out_overflow expected %b got %b", want.ovf, out_overflow); fail_count++;
        end
      end
    end
  end

  // ---------------- stimulus ----------------

  // send one vertex transaction, with a random gap before it
  // start drops only when a gap follows, so it is driven once per time step
  task automatic send_vertex(vertex_t v, logic [1:0] axis, logic last);
    int gap;
    gap = $urandom_range(0, 6);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_x <= v.x; in_y <= v.y; in_z <= v.z; in_w <= v.w;
    in_attr_a <= v.a; in_attr_b <= v.b;
    in_axis_select <= axis;
    in_last <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_vertex(v, axis, last);
    vertex_total++;
  endtask

  function automatic vertex_t make_vertex(word_t x, word_t y, word_t z, word_t w,
                                          word_t a, word_t b);
    vertex_t v;
    v.x = x; v.y = y; v.z = z; v.w = w; v.a = a; v.b = b;
    return v;
  endfunction

  // component near the w range so planes get crossed often
  function automatic word_t near_w(word_t w);
    int span;
    span = $urandom_range(0, 3);
    case (span)
      0: return word_t'($urandom);
      1: return word_t'(longint'(w) + $signed($urandom_range(0, 200)) - 100);
      default: return word_t'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
    endcase
  endfunction

  function automatic vertex_t random_vertex();
    word_t w;
    case ($urandom_range(0, 4))
      0: w = word_t'($urandom);
      1: w = word_t'(-$signed($urandom_range(0, 32'h0002_0000)));
      default: w = word_t'($urandom_range(32'h0000_8000, 32'h0002_0000));
    endcase
    return make_vertex(near_w(w), near_w(w), near_w(w), w,
                       word_t'($urandom), word_t'($urandom));
  endfunction

  task automatic send_polygon(int count, logic [1:0] axis);
    for (int i = 0; i < count; i++)
      send_vertex(random_vertex(), 2'($urandom_range(0, 3)), 1'b0);
    send_vertex(random_vertex(), axis, 1'b1);
  endtask

  // a square straddling both planes of each axis, then extremes, empty, axis three and a crossing edge
  task automatic test_directed_shapes();
    word_t one, two, big, neg;
    one = 32'sh0001_0000;
    two = 32'sh0002_0000;
    big = 32'sh7fff_ffff;
    neg = 32'sh8000_0000;
    for (int ax = 0; ax < 3; ax++) begin
      send_vertex(make_vertex(-two, -two, -two, one, 0, one), 2'(ax), 1'b0);
      send_vertex(make_vertex(two, -two, two, one, one, two), 2'(ax), 1'b0);
      send_vertex(make_vertex(two, two, two, one, two, neg), 2'(ax), 1'b0);
      send_vertex(make_vertex(-two, two, -two, one, big, big), 2'(ax), 1'b1);
    end
    // fields at extremes, w at max: the first vertex lies just outside the -w plane
    send_vertex(make_vertex(neg, big, 0, big, neg, big), AXIS_X, 1'b0);
    send_vertex(make_vertex(big, neg, -1, big, big, neg), AXIS_X, 1'b1);
    // fully outside: empty polygon
    send_vertex(make_vertex(0, 0, 0, neg, 1, 1), AXIS_Y, 1'b0);
    send_vertex(make_vertex(big, 0, 0, -one, 1, 1), AXIS_Y, 1'b1);
    // axis value three uses w alone: one vertex kept
    send_vertex(make_vertex(big, big, big, 0, 5, 6), 2'd3, 1'b1);
    // degenerate two-vertex edge crossing
    send_vertex(make_vertex(0, 0, -two, one, 0, 0), AXIS_Z, 1'b0);
    send_vertex(make_vertex(0, 0, two, one, one, one), AXIS_Z, 1'b1);
  endtask

  // more input vertices than the store holds, then a polygon that just fills it
  task automatic test_input_overflow();
    send_polygon(MAX_VERTICES + 2, AXIS_X);
    send_polygon(MAX_VERTICES - 1, AXIS_Z);
  endtask

  // a ten-vertex zigzag crossing a plane every edge overflows the clipped set
  task automatic test_clip_overflow();
    word_t one;
    one = 32'sh0001_0000;
    for (int i = 0; i < MAX_VERTICES; i++)
      send_vertex(make_vertex(i[0] ? 32'sh0003_0000 : 0, word_t'(i * 1000), 0, one,
                              word_t'($urandom), word_t'($urandom)),
                  AXIS_X, i == MAX_VERTICES - 1);
  endtask

  // hold off until the clipper has drained every result
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (clipped_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_random_polygons();
    int sent;
    sent = 0;
    while (sent < 155) begin
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_VERTICES + 1)
                                      : $urandom_range(1, 5);
      send_polygon(n, 2'($urandom_range(0, 3)));
      sent += n + 1;
      if ($urandom_range(0, 15) == 0) wait_drained();
    end
  endtask

  initial begin
    poly_ovf = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_shapes();
    test_input_overflow();
    test_clip_overflow();
    wait_drained();
    test_random_polygons();
    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d vertex transactions in %0d polygons, %0d result transactions",
             vertex_total, polygon_total, result_total);
    $display("directed squares per axis, extremes, empty, axis three, overflow, random mix");
    if (fail_count == 0 && clipped_q.size() == 0) begin
      $display("homogeneous_polygon_axis_clipper regression: pass");
    end else begin
      $display("homogeneous_polygon_axis_clipper regression: fail");
    end
    $finish;
  end

endmodule
